>>> src/xsi_pkg.sv
// Shared types and constants of the XML stream indenter.
// Used by xsi_ctrl, xsi_datapath, xml_stream_indenter_core and the testbench; no dependencies.
package xsi_pkg;

  // Tag bytes held until the tag kind is known.
  localparam int unsigned PREFIX_LEN = 9;
  localparam int unsigned PIDX_W     = 4;
  // Nesting level width, covering the largest allowed nesting limit (15).
  localparam int unsigned LVL_W      = 4;
  // Held-byte count width, covering the largest held run (16 spaces).
  localparam int unsigned BCNT_W     = 5;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Source of one output byte.
  typedef enum logic [1:0] {
    SRC_NL,
    SRC_SPACE,
    SRC_BUF,
    SRC_CHAR
  } src_e;

  // Datapath to controller: what the offered byte would produce.
  typedef struct packed {
    logic              nl;        // deferred line break goes out first
    logic [LVL_W-1:0]  indent;    // indentation level, two spaces each
    logic [BCNT_W-1:0] buf_cnt;   // held bytes to replay
    logic              has_char;  // the byte itself follows
    logic              slot_free; // output register can take a byte
  } stat_t;

  // Controller to datapath.
  typedef struct packed {
    logic              accept;
    logic              emit;
    src_e              src;
    logic [BCNT_W-1:0] idx;
    logic              last;
  } cmd_t;

endpackage

>>> src/xsi_ctrl.sv
// Output sequencer of the XML stream indenter: takes one byte, then walks
// line break, indentation, held bytes and the byte itself. Depends on xsi_pkg.
module xsi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  xsi_pkg::stat_t stat_i,
  output xsi_pkg::cmd_t  cmd_o
);
  import xsi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NL,
    ST_IND,
    ST_BUF,
    ST_CHAR
  } state_e;

  state_e              state_q, state_d;
  logic [LVL_W:0]      ind_left_q, ind_left_d;
  logic [BCNT_W-1:0]   buf_left_q, buf_left_d;
  logic [BCNT_W-1:0]   buf_idx_q, buf_idx_d;
  logic                has_char_q, has_char_d;

  // First phase that still has bytes to send.
  function automatic state_e pick(input logic nl, input logic [LVL_W:0] ind,
                                  input logic [BCNT_W-1:0] bl, input logic ch);
    state_e s;
    if (nl) s = ST_NL;
    else if (ind != '0) s = ST_IND;
    else if (bl != '0) s = ST_BUF;
    else if (ch) s = ST_CHAR;
    else s = ST_IDLE;
    return s;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    ind_left_d = ind_left_q;
    buf_left_d = buf_left_q;
    buf_idx_d  = buf_idx_q;
    has_char_d = has_char_q;
    cmd_o      = '0;
    cmd_o.src  = SRC_NL;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          ind_left_d   = {stat_i.indent, 1'b0};
          buf_left_d   = stat_i.buf_cnt;
          buf_idx_d    = '0;
          has_char_d   = stat_i.has_char;
          state_d      = pick(stat_i.nl, {stat_i.indent, 1'b0}, stat_i.buf_cnt,
                              stat_i.has_char);
        end
      end
      ST_NL: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_NL;
          state_d    = pick(1'b0, ind_left_q, buf_left_q, has_char_q);
        end
      end
      ST_IND: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_SPACE;
          ind_left_d = ind_left_q - 1'b1;
          state_d    = pick(1'b0, ind_left_d, buf_left_q, has_char_q);
        end
      end
      ST_BUF: begin
        cmd_o.idx = buf_idx_q;
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_BUF;
          buf_idx_d  = buf_idx_q + 1'b1;
          buf_left_d = buf_left_q - 1'b1;
          state_d    = pick(1'b0, '0, buf_left_d, has_char_q);
        end
      end
      ST_CHAR: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_CHAR;
          has_char_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.last = cmd_o.emit && (state_d == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ind_left_q <= '0;
      buf_left_q <= '0;
      buf_idx_q  <= '0;
      has_char_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ind_left_q <= ind_left_d;
      buf_left_q <= buf_left_d;
      buf_idx_q  <= buf_idx_d;
      has_char_q <= has_char_d;
    end
  end

`ifndef ASSERT_OFF
  // The last byte of a run always returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == ST_IDLE)
    else $error("sequencer left idle after last byte");
  // Held-byte replay never runs past its count.
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BUF |-> buf_left_q != '0)
    else $error("held-byte replay with nothing left");
`endif

endmodule

>>> src/xsi_datapath.sv
// Document state, tag prefix and whitespace buffers, output register of the
// XML stream indenter. Driven by xsi_ctrl commands. Depends on xsi_pkg.
module xsi_datapath #(
  parameter int unsigned NEST_LIMIT  = 15,
  parameter int unsigned SPACE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     in_byte_i,
  input  logic           in_eod_i,
  input  xsi_pkg::cmd_t  cmd_i,
  output xsi_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           out_flag_o
);
  import xsi_pkg::*;

  localparam int unsigned SCNT_W = $clog2(SPACE_DEPTH + 1);
  localparam int unsigned SIDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  typedef enum logic [2:0] {
    KIND_UNDECIDED,
    KIND_ORDINARY,
    KIND_CLOSING,
    KIND_DECL,
    KIND_COMMENT,
    KIND_CDATA
  } kind_e;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CDATA_PAT [8] = '{8'h21, 8'h5B, 8'h43, 8'h44,
                                           8'h41, 8'h54, 8'h41, 8'h5B};

  // Document state.
  logic              inside_q, inside_d;
  logic [PIDX_W-1:0] pcnt_q, pcnt_d;
  kind_e             kind_q, kind_d;
  logic [1:0]        tlen_q, tlen_d;
  logic [7:0]        prev_q, prev_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              pend_q, pend_d;
  logic              text_q, text_d;
  logic [SCNT_W-1:0] scnt_q, scnt_d;
  logic              ovf_q, ovf_d;

  // Held bytes, replayed after the transfer that fills them.
  logic [7:0]        prefix_q [PREFIX_LEN];
  logic [7:0]        space_q  [SPACE_DEPTH];
  logic              pre_we, sp_we;
  logic [PIDX_W-1:0] pre_widx;

  // Per-item replay context.
  logic [7:0]        char_q;
  logic              flag_q, flag_d;
  logic              sel_pre_q, sel_pre_d;

  // Output register.
  logic              oval_q;
  logic [7:0]        obyte_q;
  logic              olast_q, oflag_q;
  logic [7:0]        emit_byte;

  // Tag classification of the offered byte.
  logic [PIDX_W-1:0] idx;
  logic [2:0]        pos;
  logic              is_cmt;
  logic              pat_ok;
  kind_e             kind_new;
  logic [LVL_W-1:0]  lvl_tag;
  logic              self_close;
  logic              is_ws;

  always_comb begin
    idx    = pcnt_q;
    pos    = 3'(idx - 1'b1);
    is_cmt = (idx == PIDX_W'(2)) ? (in_byte_i == CH_DASH) : (prefix_q[2] == CH_DASH);
    if (is_cmt) pat_ok = (pos < 3'd3) && (in_byte_i == CH_DASH) && (pos != 3'd0);
    else pat_ok = (in_byte_i == CDATA_PAT[pos]);
    kind_new = kind_q;
    if (idx == PIDX_W'(1)) begin
      if (in_byte_i == CH_SLASH) kind_new = KIND_CLOSING;
      else if (in_byte_i == CH_QUEST) kind_new = KIND_DECL;
      else if (in_byte_i != CH_BANG) kind_new = KIND_ORDINARY;
    end else begin
      if (!pat_ok) kind_new = KIND_ORDINARY;
      else if (is_cmt && pos == 3'd2) kind_new = KIND_COMMENT;
      else if (!is_cmt && pos == 3'd7) kind_new = KIND_CDATA;
    end
    if (kind_new == KIND_UNDECIDED && idx >= PIDX_W'(PREFIX_LEN - 1))
      kind_new = KIND_ORDINARY;
  end

  assign is_ws = (in_byte_i == CH_SPACE) || (in_byte_i inside {[8'h09:8'h0D]});

  always_comb begin
    inside_d  = inside_q;
    pcnt_d    = pcnt_q;
    kind_d    = kind_q;
    tlen_d    = tlen_q;
    prev_d    = prev_q;
    lvl_d     = lvl_q;
    pend_d    = pend_q;
    text_d    = text_q;
    scnt_d    = scnt_q;
    ovf_d     = ovf_q;
    flag_d    = flag_q;
    sel_pre_d = sel_pre_q;
    pre_we    = 1'b0;
    pre_widx  = pcnt_q;
    sp_we     = 1'b0;
    lvl_tag   = lvl_q;
    self_close = (tlen_q >= 2'd2) && (prev_q == CH_SLASH);

    stat_o           = '0;
    stat_o.slot_free = !oval_q || out_ready_i;

    if (inside_q) begin
      if (kind_q == KIND_UNDECIDED) begin
        pre_we    = 1'b1;
        pcnt_d    = pcnt_q + 1'b1;
        kind_d    = kind_new;
        sel_pre_d = 1'b1;
        if (kind_new == KIND_CLOSING && lvl_q != '0) lvl_tag = lvl_q - 1'b1;
        lvl_d = lvl_tag;
        if (kind_new != KIND_UNDECIDED || in_eod_i) begin
          stat_o.nl      = pend_q;
          stat_o.buf_cnt = BCNT_W'(pcnt_d);
          pend_d         = 1'b0;
          if (kind_new == KIND_UNDECIDED || kind_new == KIND_ORDINARY ||
              kind_new == KIND_CLOSING) begin
            stat_o.indent = lvl_tag;
          end
        end
      end else begin
        stat_o.has_char = 1'b1;
      end
      if (in_byte_i == CH_GT) begin
        if (kind_d == KIND_ORDINARY && !self_close && lvl_tag < LVL_W'(NEST_LIMIT))
          lvl_d = lvl_tag + 1'b1;
        pend_d   = 1'b1;
        inside_d = 1'b0;
      end else begin
        prev_d = in_byte_i;
        if (tlen_q != 2'd3) tlen_d = tlen_q + 1'b1;
      end
    end else if (in_byte_i == CH_LT) begin
      pend_d    = pend_q || text_q;
      text_d    = 1'b0;
      scnt_d    = '0;
      ovf_d     = 1'b0;
      inside_d  = 1'b1;
      pre_we    = 1'b1;
      pre_widx  = '0;
      pcnt_d    = PIDX_W'(1);
      kind_d    = KIND_UNDECIDED;
      tlen_d    = 2'd1;
      prev_d    = in_byte_i;
      sel_pre_d = 1'b1;
      if (in_eod_i) begin
        stat_o.nl      = pend_q || text_q;
        stat_o.indent  = lvl_q;
        stat_o.buf_cnt = BCNT_W'(1);
      end
    end else if (text_q) begin
      stat_o.has_char = 1'b1;
    end else if (is_ws) begin
      if (scnt_q < SCNT_W'(SPACE_DEPTH)) begin
        sp_we  = 1'b1;
        scnt_d = scnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end else begin
      stat_o.nl       = pend_q;
      stat_o.indent   = lvl_q;
      stat_o.buf_cnt  = BCNT_W'(scnt_q);
      stat_o.has_char = 1'b1;
      flag_d    = ovf_q;
      sel_pre_d = 1'b0;
      pend_d    = 1'b0;
      text_d    = 1'b1;
      scnt_d    = '0;
      ovf_d     = 1'b0;
    end

    // Per-item flag is zero unless this item flushes an overflowed run.
    if (!(!inside_q && in_byte_i != CH_LT && !text_q && !is_ws)) flag_d = 1'b0;

    // End of document: return to the reset state.
    if (in_eod_i) begin
      inside_d = 1'b0;
      pcnt_d   = '0;
      kind_d   = KIND_UNDECIDED;
      tlen_d   = '0;
      prev_d   = '0;
      lvl_d    = '0;
      pend_d   = 1'b0;
      text_d   = 1'b0;
      scnt_d   = '0;
      ovf_d    = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_NL:    emit_byte = CH_NL;
      SRC_SPACE: emit_byte = CH_SPACE;
      SRC_BUF:   emit_byte = sel_pre_q ? prefix_q[cmd_i.idx[PIDX_W-1:0]]
                                       : space_q[cmd_i.idx[SIDX_W-1:0]];
      SRC_CHAR:  emit_byte = char_q;
      default:   emit_byte = char_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      pcnt_q    <= '0;
      kind_q    <= KIND_UNDECIDED;
      tlen_q    <= '0;
      prev_q    <= '0;
      lvl_q     <= '0;
      pend_q    <= 1'b0;
      text_q    <= 1'b0;
      scnt_q    <= '0;
      ovf_q     <= 1'b0;
      oval_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        inside_q <= inside_d;
        pcnt_q   <= pcnt_d;
        kind_q   <= kind_d;
        tlen_q   <= tlen_d;
        prev_q   <= prev_d;
        lvl_q    <= lvl_d;
        pend_q   <= pend_d;
        text_q   <= text_d;
        scnt_q   <= scnt_d;
        ovf_q    <= ovf_d;
      end
      if (cmd_i.emit) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q    <= in_byte_i;
      flag_q    <= flag_d;
      sel_pre_q <= sel_pre_d;
      if (pre_we) prefix_q[pre_widx] <= in_byte_i;
      if (sp_we) space_q[scnt_q[SIDX_W-1:0]] <= in_byte_i;
    end
    if (cmd_i.emit) begin
      obyte_q <= emit_byte;
      olast_q <= cmd_i.last;
      oflag_q <= flag_q;
    end
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_flag_o  = oflag_q;

`ifndef ASSERT_OFF
  a_lvl_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_W'(NEST_LIMIT))
    else $error("nesting level above limit");
  a_tag_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> pcnt_q != '0)
    else $error("open tag with no held bytes");
  a_prefix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inside_q && kind_q == KIND_UNDECIDED) |-> pcnt_q < PIDX_W'(PREFIX_LEN))
    else $error("undecided tag with full prefix");
  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= SCNT_W'(SPACE_DEPTH))
    else $error("whitespace count above buffer depth");
`endif

endmodule

>>> src/xml_stream_indenter_core.sv
// Top level of the XML stream indenter: sequencer and datapath.
// Depends on xsi_pkg, xsi_ctrl and xsi_datapath.
//
//  channel  | dir | tdata            | tlast           | tuser
//  s_axis   | in  | [7:0] in_byte    | end_of_document | -
//  m_axis   | out | [7:0] out_byte   | last_of_run     | whitespace_dropped
//
// An input byte is taken only while the sequencer is idle; the single
// output sequencer then replays line break, indentation and held bytes
// and sends the byte itself, up to 48 result bytes, before it takes the
// next input byte. A stalled output holds the sequencer in place. Reset
// is asynchronous, active low, and clears the document state; the tag
// and whitespace buffers are not cleared.
module xml_stream_indenter_core #(
  parameter int unsigned NEST_LIMIT  = 15,
  parameter int unsigned SPACE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_document
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // last_of_run
  output logic       m_axis_tuser_o    // whitespace_dropped
);
  import xsi_pkg::*;

  // Command and status between sequencer and datapath.
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accept a byte while idle, then advance through the
  // line break, indentation, held bytes and the byte itself.
  xsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: classify tags, track nesting, hold whitespace, and drive
  // the output register that decouples the master side.
  xsi_datapath #(
    .NEST_LIMIT  (NEST_LIMIT),
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata_i),
    .in_eod_i    (s_axis_tlast_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_flag_o  (m_axis_tuser_o)
  );

endmodule

>>> tb/tb_xml_stream_indenter_core.sv
// Self-checking testbench for xml_stream_indenter_core: streams XML documents in
// and checks every indented output byte against an in-bench pretty printer.
// Depends on xsi_pkg and the RTL under src; reads no files.
module tb_xml_stream_indenter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import xsi_pkg::*;

  localparam int NEST_LIMIT    = 15;
  localparam int SPACE_DEPTH   = 16;
  localparam int RANDOM_BYTES  = 120;     // stop adding random documents once this many are queued
  localparam int QUIET_TAIL    = 40;      // last bytes run with no idling at all
  localparam int HOLD_START    = 60;      // bytes in before the long receiver hold
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 40;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZED   = 8'h7A;

  // Opening sequences, first character in the top byte.
  localparam logic [23:0] COMMENT_OPEN = "!--";
  localparam logic [63:0] CDATA_OPEN   = "![CDATA[";

  typedef enum logic [2:0] {
    KIND_UNDECIDED,
    KIND_ORDINARY,
    KIND_CLOSING,
    KIND_DECL,
    KIND_COMMENT,
    KIND_CDATA
  } tag_kind_e;

  typedef enum logic [1:0] {
    DOC_PLAIN,
    DOC_DEEP,
    DOC_SPACES,
    DOC_NOISE
  } doc_shape_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eod;
    logic       pause;   // hold this byte until every pending output has drained
  } doc_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       dropped;
  } text_beat_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  xml_stream_indenter_core #(
    .NEST_LIMIT (NEST_LIMIT),
    .SPACE_DEPTH(SPACE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast),
    .m_axis_tuser_o (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Pretty-printer state, mirrored from the block's document state.
  // ---------------------------------------------------------------------------
  logic        tag_open;
  logic [7:0]  held [PREFIX_LEN];
  int unsigned held_n;
  tag_kind_e   kind;
  int unsigned tag_len;
  logic [7:0]  prev_tag_ch;
  int unsigned level;
  logic        break_due;
  logic        in_text;
  logic [7:0]  blanks [SPACE_DEPTH];
  int unsigned blank_n;
  logic        blanks_lost;

  text_beat_t  expected_text[$];
  logic        step_flag;
  int          step_n;

  doc_byte_t   doc_bytes[$];
  doc_byte_t   next_byte;
  text_beat_t  want;
  logic        pause_next = 1'b0;

  int          total_bytes   = 0;
  int          bytes_in      = 0;
  int          beats_checked = 0;
  int          mismatches    = 0;
  int          docs          = 0;
  int          deepest       = 0;
  int          flagged_runs  = 0;
  int          cycles        = 0;
  int          send_gap      = 0;
  int          rx_stall      = 0;
  logic        in_taken      = 1'b0;
  logic        idle_on       = 1'b1;
  logic        rx_hold       = 1'b0;

  function automatic void clear_document();
    tag_open    = 1'b0;
    held_n      = 0;
    kind        = KIND_UNDECIDED;
    tag_len     = 0;
    prev_tag_ch = 8'h00;
    level       = 0;
    break_due   = 1'b0;
    in_text     = 1'b0;
    blank_n     = 0;
    blanks_lost = 1'b0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    text_beat_t beat;
    beat.ch      = b;
    beat.run_end = 1'b0;
    beat.dropped = step_flag;
    expected_text.insert(expected_text.size(), beat);
    step_n++;
  endfunction

  // Emit the deferred line break, then the indentation if the line takes it.
  function automatic void start_line(input logic indent);
    if (break_due) begin
      put_byte(CH_NL);
      break_due = 1'b0;
    end
    if (indent) begin
      for (int i = 0; i < level; i++) begin
        put_byte(CH_SPACE);
        put_byte(CH_SPACE);
      end
    end
  endfunction

  function automatic void release_held();
    for (int i = 0; i < held_n && i < PREFIX_LEN; i++) put_byte(held[i]);
  endfunction

  // Work out every output byte that one document byte causes.
  function automatic void indent_byte(input logic [7:0] ch, input logic eod);
    int unsigned idx;
    int unsigned pos;
    int unsigned plen;
    logic        is_cmt;
    logic        self_close;
    logic [7:0]  pat_ch;
    text_beat_t  beat;
    step_n    = 0;
    step_flag = 1'b0;
    if (tag_open) begin
      if (kind == KIND_UNDECIDED) begin
        idx = held_n;
        if (idx < PREFIX_LEN) begin
          held[idx] = ch;
          held_n    = idx + 1;
        end
        // Classify from the held prefix: second byte first, then "!--" or "![CDATA[".
        if (idx == 1) begin
          if (ch == CH_SLASH) kind = KIND_CLOSING;
          else if (ch == CH_QMARK) kind = KIND_DECL;
          else if (ch != CH_BANG) kind = KIND_ORDINARY;
        end else begin
          is_cmt = (held[2] == CH_DASH);
          plen   = is_cmt ? 3 : 8;
          pos    = idx - 1;
          if (pos >= plen) begin
            kind = KIND_ORDINARY;
          end else begin
            pat_ch = is_cmt ? COMMENT_OPEN[8*(2-pos) +: 8] : CDATA_OPEN[8*(7-pos) +: 8];
            if (ch != pat_ch) kind = KIND_ORDINARY;
            else if (pos == plen - 1) kind = is_cmt ? KIND_COMMENT : KIND_CDATA;
          end
        end
        if (kind == KIND_UNDECIDED && held_n >= PREFIX_LEN) kind = KIND_ORDINARY;

        if (kind != KIND_UNDECIDED) begin
          if (kind == KIND_CLOSING && level > 0) level--;
          start_line(kind == KIND_ORDINARY || kind == KIND_CLOSING);
          release_held();
        end else if (eod) begin
          // Document ends while the tag is still held: flush it at the current level.
          start_line(1'b1);
          release_held();
        end
      end else begin
        put_byte(ch);
      end

      if (ch == CH_GT) begin
        self_close = (tag_len >= 2) && (prev_tag_ch == CH_SLASH);
        if (kind == KIND_ORDINARY && !self_close && level < NEST_LIMIT) begin
          level++;
          if (level > deepest) deepest = level;
        end
        break_due = 1'b1;
        tag_open  = 1'b0;
      end else begin
        prev_tag_ch = ch;
        if (tag_len < 3) tag_len++;
      end
    end else if (ch == CH_LT) begin
      if (in_text) break_due = 1'b1;
      in_text     = 1'b0;
      blank_n     = 0;
      blanks_lost = 1'b0;
      tag_open    = 1'b1;
      held[0]     = ch;
      held_n      = 1;
      kind        = KIND_UNDECIDED;
      tag_len     = 1;
      prev_tag_ch = ch;
      if (eod) begin
        start_line(1'b1);
        release_held();
      end
    end else if (in_text) begin
      put_byte(ch);
    end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= 8'h0D)) begin
      if (blank_n < SPACE_DEPTH) begin
        blanks[blank_n] = ch;
        blank_n++;
      end else begin
        blanks_lost = 1'b1;
      end
    end else begin
      // First real text byte: flush the line start and the held whitespace.
      step_flag = blanks_lost;
      if (blanks_lost) flagged_runs++;
      start_line(1'b1);
      for (int i = 0; i < blank_n; i++) put_byte(blanks[i]);
      put_byte(ch);
      in_text     = 1'b1;
      blank_n     = 0;
      blanks_lost = 1'b0;
    end

    if (step_n > 0) begin
      beat         = expected_text[expected_text.size() - 1];
      beat.run_end = 1'b1;
      expected_text[expected_text.size() - 1] = beat;
    end
    if (eod) clear_document();
  endfunction

  // ---------------------------------------------------------------------------
  // Document generation.
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    doc_byte_t d;
    d.ch    = b;
    d.eod   = 1'b0;
    d.pause = pause_next;
    pause_next = 1'b0;
    doc_bytes.insert(doc_bytes.size(), d);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void end_document();
    doc_byte_t d;
    d     = doc_bytes[doc_bytes.size() - 1];
    d.eod = 1'b1;
    doc_bytes[doc_bytes.size() - 1] = d;
    docs++;
  endfunction

  function automatic void add_name();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) add_byte(8'(8'h61 + $urandom_range(0, 25)));
  endfunction

  function automatic void add_open();
    add_byte(CH_LT);
    add_name();
    if ($urandom_range(0, 2) == 0) add_text(" k=\"v\"");
    add_byte(CH_GT);
  endfunction

  function automatic void add_close();
    add_text("</");
    add_name();
    add_byte(CH_GT);
  endfunction

  // Leading whitespace of any kind, then up to max_chars arbitrary bytes other than '<'.
  function automatic void add_text_run(input int min_ws, input int max_ws,
                                       input int max_chars);
    int         n;
    int         r;
    logic [7:0] b;
    n = $urandom_range(min_ws, max_ws);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 6);
      add_byte(r >= 5 ? CH_SPACE : 8'(CH_TAB + r));
    end
    n = (max_chars == 0) ? 0 : $urandom_range(1, max_chars);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      add_byte(b == CH_LT ? CH_ZED : b);
    end
  endfunction

  function automatic void random_document(input doc_shape_e shape);
    int depth;
    int tokens;
    int r;
    depth = 0;
    case (shape)
      DOC_DEEP: begin
        // Nest one past the limit, then put the widest possible line at the bottom:
        // line break, full indentation, a full whitespace buffer and one text byte.
        for (int i = 0; i < NEST_LIMIT + 1; i++) begin
          add_byte(CH_LT);
          add_byte(8'(8'h61 + $urandom_range(0, 25)));
          add_byte(CH_GT);
        end
        add_text_run(SPACE_DEPTH + 1, SPACE_DEPTH + 1, 0);
        add_byte(CH_ZED);
        add_close();
      end
      DOC_SPACES: begin
        add_text("<r>");
        add_text_run(SPACE_DEPTH + 1, SPACE_DEPTH + 8, 4);
        add_text("</r><r>");
        add_text_run(SPACE_DEPTH + 1, SPACE_DEPTH + 4, 0);
        add_text("</r>");
      end
      DOC_NOISE: begin
        tokens = $urandom_range(8, 16);
        for (int i = 0; i < tokens; i++) begin
          r = $urandom_range(0, 3);
          add_byte(r == 0 ? CH_LT : r == 1 ? CH_GT : 8'($urandom_range(0, 255)));
        end
      end
      default: begin
        tokens = $urandom_range(3, 9);
        for (int t = 0; t < tokens; t++) begin
          case ($urandom_range(0, 11))
            0, 1, 2: begin
              add_open();
              depth++;
            end
            3, 4: begin
              add_close();
              if (depth > 0) depth--;
            end
            5: begin
              add_byte(CH_LT);
              add_name();
              if ($urandom_range(0, 1) == 0) add_byte(CH_SPACE);
              add_text("/>");
            end
            6, 7: add_text_run(0, 3, 6);
            8:    add_text_run(1, 4, 0);
            9: begin
              add_text("<!--");
              add_text_run(0, 1, 5);
              add_text("-->");
            end
            10: begin
              if ($urandom_range(0, 1) == 0) begin
                add_text("<![CDATA[");
                add_text_run(0, 1, 4);
                add_text("]]>");
              end else begin
                add_text("<?");
                add_name();
                add_text("?>");
              end
            end
            default: begin
              // Near misses of the special openings, and degenerate tags.
              case ($urandom_range(0, 5))
                0:       add_text("<!-x>");
                1:       add_text("<![CDAx>");
                2:       add_text("<!>");
                3:       add_text("<>");
                4:       add_text("<!DOCTYPE r>");
                default: add_text("< />");
              endcase
            end
          endcase
        end
        if ($urandom_range(0, 4) == 0) begin
          // Cut the document off inside a tag, held or already released.
          case ($urandom_range(0, 5))
            0:       add_byte(CH_LT);
            1:       add_text("<!-");
            2:       add_text("<![CDA");
            3:       add_text("<abcdefghijk");
            4:       add_text("</xy");
            default: add_text("<!--ab");
          endcase
        end else begin
          for (; depth > 0; depth--) add_close();
        end
      end
    endcase
    end_document();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer the next byte at the falling edge; hold it until transferred.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (doc_bytes.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (doc_bytes[0].pause && expected_text.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          next_byte     = doc_bytes.pop_front();
          s_axis_tdata  <= next_byte.ch;
          s_axis_tlast  <= next_byte.eod;
          s_axis_tvalid <= 1'b1;
          if (idle_on && total_bytes - bytes_in > QUIET_TAIL && $urandom_range(0, 3) == 0)
            send_gap <= $urandom_range(1, 5);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold driven below.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        m_axis_tready <= 1'b0;
        rx_stall      <= rx_stall - 1;
      end else if (idle_on && total_bytes - bytes_in > QUIET_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        rx_stall      <= $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hold off the output long enough for the block to back up into its input.
  initial begin
    wait (bytes_in >= HOLD_START);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge, check output first.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles: %0d of %0d bytes in, %0d output bytes due",
               cycles, bytes_in, total_bytes, expected_text.size());
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", m_axis_tdata));
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata !== want.ch)
            report_mismatch($sformatf("out byte %0d: got %02h, want %02h",
                                      beats_checked, m_axis_tdata, want.ch));
          if (m_axis_tlast !== want.run_end)
            report_mismatch($sformatf("out byte %0d: last_of_run %b, want %b",
                                      beats_checked, m_axis_tlast, want.run_end));
          if (m_axis_tuser !== want.dropped)
            report_mismatch($sformatf("out byte %0d: whitespace_dropped %b, want %b",
                                      beats_checked, m_axis_tuser, want.dropped));
          beats_checked <= beats_checked + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        indent_byte(s_axis_tdata, s_axis_tlast);
        bytes_in <= bytes_in + 1;
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (cycles % 48 == 0) idle_on <= ($urandom_range(0, 2) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    clear_document();

    // Closing tag at level zero, bare declaration, held blank before a zero byte,
    // stray '>', an all-ones byte, then the document ends on '<'.
    add_text("</q><?> ");
    add_byte(8'h00);
    add_byte(CH_GT);
    add_byte(8'hFF);
    add_byte(CH_LT);
    end_document();
    // Self-closing tag, empty comment, and a CDATA opening still held at the end.
    add_text("<b/><!----><![C");
    end_document();

    random_document(DOC_DEEP);
    pause_next = 1'b1;
    while (doc_bytes.size() < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0:       random_document(DOC_NOISE);
        1:       random_document(DOC_SPACES);
        default: random_document(DOC_PLAIN);
      endcase
      if ($urandom_range(0, 5) == 0) pause_next = 1'b1;
    end
    total_bytes = doc_bytes.size();

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_in != total_bytes || expected_text.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Ran %0d documents, %0d bytes in, %0d bytes out; nesting reached %0d,",
             docs, bytes_in, beats_checked, deepest);
    $display("%0d lines flagged for lost whitespace, %0d mismatches.",
             flagged_runs, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
